// ===== hw/rtl/mpsd_pkg.sv =====
package mpsd_pkg;

  // pot slots built into the block
  localparam int unsigned POT_SLOTS = 4;
  localparam int unsigned POT_W     = $clog2(POT_SLOTS);
  localparam int unsigned CNT_POT_W = 3;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned TAKEN_W  = 8;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // adc full scale and settling discard count
  localparam logic [SAMPLE_W-1:0] ADC_FULL      = 12'd4095;
  localparam logic [1:0]          DISCARD_COUNT = 2'd3;

  // mean divider: sample sum over the sample count
  localparam int unsigned DIV_W     = SUM_W;
  localparam int unsigned DIVISOR_W = TAKEN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // scale by 4095: 12x16 product, folded a few times since 4095 = 2^12 - 1
  localparam int unsigned PROD_W     = SAMPLE_W + VALUE_W;
  localparam int unsigned FOLD_STEPS = 3;
  localparam int unsigned FOLD_CNT_W = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POT_COUNT   = 3'd0,
    CFG_SAMPLES     = 3'd1,
    CFG_OUT_BITS    = 3'd2,
    CFG_MARGIN      = 3'd3,
    CFG_CHANNEL_MAP = 3'd4
  } cfg_idx_e;

  // micro-operations driving the datapath
  typedef enum logic [2:0] {
    OP_FRONT     = 3'd0,
    OP_DIV_MEAN  = 3'd1,
    OP_WAIT      = 3'd2,
    OP_DIV_SCALE = 3'd3,
    OP_UPDATE    = 3'd4
  } uop_e;

  // jump conditions
  typedef enum logic [1:0] {
    COND_NEXT       = 2'd0,
    COND_ALWAYS     = 2'd1,
    COND_NO_READING = 2'd2,
    COND_DIV_BUSY   = 2'd3
  } cond_e;

  localparam int unsigned UPC_W = 3;

  typedef struct packed {
    uop_e             op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic reading_done;
    logic div_busy;
  } seq_status_t;

  // control program: front end, mean divide, scale fold, compare and store
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      3'd0:    w = '{op: OP_FRONT,     cond: COND_NO_READING, target: 3'd0};
      3'd1:    w = '{op: OP_DIV_MEAN,  cond: COND_NEXT,       target: 3'd0};
      3'd2:    w = '{op: OP_WAIT,      cond: COND_DIV_BUSY,   target: 3'd2};
      3'd3:    w = '{op: OP_DIV_SCALE, cond: COND_NEXT,       target: 3'd0};
      3'd4:    w = '{op: OP_WAIT,      cond: COND_DIV_BUSY,   target: 3'd4};
      3'd5:    w = '{op: OP_UPDATE,    cond: COND_ALWAYS,     target: 3'd0};
      default: w = '{op: OP_WAIT,      cond: COND_ALWAYS,     target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/mpsd_stream_if.sv =====
// adc sample channel
interface mpsd_adc_if;
  logic        valid;
  logic        ready;
  logic [11:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

// result channel
interface mpsd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mux_select;
  logic        event_valid;
  logic [1:0]  event_pot;
  logic [15:0] event_value;
  logic        scan_wrap;

  modport source (output valid, output mux_select, output event_valid, output event_pot,
                  output event_value, output scan_wrap, input ready);
  modport sink   (input valid, input mux_select, input event_valid, input event_pot,
                  input event_value, input scan_wrap, output ready);
endinterface

// ===== hw/rtl/mpsd_divider.sv =====
module mpsd_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mpsd_pkg::DIV_W-1:0]     dividend_i,
  input  logic [mpsd_pkg::DIVISOR_W-1:0] divisor_i,
  output logic                            busy_o,
  output logic [mpsd_pkg::DIV_W-1:0]     quotient_o
);
  import mpsd_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;

  // one restoring step per cycle, msb first
  always_comb begin
    shifted = {rem_q, quo_q[DIV_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      cnt_d = DIV_CNT_W'(DIV_W);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!diff[DIVISOR_W]) begin
        rem_d = diff[DIVISOR_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIVISOR_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

  // a fresh start only comes while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> cnt_q == '0)
    else $error("divider restarted while busy");
  // a start always runs for the full step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   start_i |=> cnt_q == DIV_CNT_W'(DIV_W))
    else $error("divider step count not loaded");
  // divisor never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> divisor_i != '0)
    else $error("divide by zero");

endmodule

// ===== hw/rtl/mpsd_sequencer.sv =====
module mpsd_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mpsd_pkg::seq_status_t stat_i,
  output mpsd_pkg::uword_t      uword_o
);
  import mpsd_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           uw;
  logic             take_jump;

  // fetch control word and pick the next step
  always_comb begin
    uw = ucode_rom(upc_q);
    case (uw.cond)
      COND_NEXT:       take_jump = 1'b0;
      COND_ALWAYS:     take_jump = 1'b1;
      COND_NO_READING: take_jump = !stat_i.reading_done;
      COND_DIV_BUSY:   take_jump = stat_i.div_busy;
      default:         take_jump = 1'b1;
    endcase
    upc_d = take_jump ? uw.target : upc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= '0;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign uword_o = uw;

  // a finished reading always leads into the mean divide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (uw.op == OP_FRONT) && stat_i.reading_done |=> uword_o.op == OP_DIV_MEAN)
    else $error("reading done but no divide");
  // the front end step is never left without a finished reading
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (uw.op == OP_FRONT) && !stat_i.reading_done |=> uword_o.op == OP_FRONT)
    else $error("front end left early");
  // the step counter stays within the control program
  assert property (@(posedge clk_i) disable iff (!rst_ni) upc_q <= UPC_W'(5))
    else $error("step counter out of program");

endmodule

// ===== hw/rtl/muxed_pot_scan_deadband_core.sv =====
// results: an item that discards or adds a sample gives its registered result in the cycle
// after acceptance; an item that finishes a reading gives its result only after a 20-step
// mean divide on the one-bit-per-cycle divider, then a 3-step fold for the scale by 4095
// throughput: 1 item per cycle while sampling, stalled by results and the divide steps
// reset: config to defaults, scan at pot 0 with 3 discards, stored values all zero
module muxed_pot_scan_deadband_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mpsd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mpsd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  mpsd_adc_if.sink                          adc_i,
  mpsd_res_if.source                        res_o
);
  import mpsd_pkg::*;

  // configuration registers
  logic [CNT_POT_W-1:0]      pot_count_q;
  logic [TAKEN_W-1:0]        samples_q;
  logic [4:0]                out_bits_q;
  logic [VALUE_W-1:0]        margin_q;
  logic [2*POT_SLOTS-1:0]    chan_map_q;

  // scan state
  logic [POT_W-1:0]          cur_pot_q;
  logic [1:0]                disc_q;
  logic [TAKEN_W-1:0]        taken_q;
  logic [SUM_W-1:0]          sum_q;
  logic [VALUE_W-1:0]        last_q [POT_SLOTS];

  // result register
  logic                      out_valid_q;
  logic [CHAN_W-1:0]         mux_q;
  logic                      ev_valid_q;
  logic [POT_W-1:0]          ev_pot_q;
  logic [VALUE_W-1:0]        ev_value_q;
  logic                      wrap_q;

  uword_t                    uw;
  seq_status_t               stat;
  logic                      div_start;
  logic [DIV_W-1:0]          div_dividend;
  logic [DIVISOR_W-1:0]      div_divisor;
  logic                      div_busy;
  logic [DIV_W-1:0]          div_quo;

  logic                      acc;
  logic                      out_free;
  logic [CNT_POT_W-1:0]      count_eff;
  logic                      idle;
  logic                      restart;
  logic [POT_W-1:0]          pot_f;
  logic [1:0]                disc_f;
  logic [TAKEN_W-1:0]        taken_f;
  logic [SUM_W-1:0]          sum_f;
  logic                      discarding;
  logic [SUM_W-1:0]          sum_n;
  logic [TAKEN_W-1:0]        taken_n;
  logic [TAKEN_W-1:0]        n_eff;
  logic                      done;
  logic [POT_W-1:0]          front_pot;

  logic [4:0]                bits_eff;
  logic [VALUE_W-1:0]        top;
  logic [SAMPLE_W-1:0]       mean_c;
  logic [PROD_W-1:0]         product;

  logic [FOLD_CNT_W-1:0]     fold_cnt_q, fold_cnt_d;
  logic [PROD_W-1:0]         fold_r_q, fold_r_d;
  logic [VALUE_W-1:0]        fold_q_q, fold_q_d;
  logic [PROD_W-SAMPLE_W-1:0] fold_hi;
  logic [SAMPLE_W-1:0]       fold_lo;
  logic                      fold_busy;

  logic [VALUE_W-1:0]        val;
  logic [VALUE_W-1:0]        prev;
  logic                      changed;
  logic [CNT_POT_W-1:0]      pot_inc;
  logic                      wrap;
  logic [POT_W-1:0]          next_pot;

  // control program
  mpsd_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .uword_o (uw)
  );

  // iterative divider for the mean
  mpsd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // handshake
  assign out_free    = !out_valid_q || res_o.ready;
  assign adc_i.ready = (uw.op == OP_FRONT) && out_free;
  assign acc         = adc_i.valid && adc_i.ready;

  // front end: restart, discard or accumulate
  always_comb begin
    count_eff  = (pot_count_q > CNT_POT_W'(POT_SLOTS)) ? CNT_POT_W'(POT_SLOTS) : pot_count_q;
    idle       = (count_eff == '0);
    restart    = ({1'b0, cur_pot_q} >= count_eff);
    pot_f      = restart ? '0 : cur_pot_q;
    disc_f     = restart ? DISCARD_COUNT : disc_q;
    taken_f    = restart ? '0 : taken_q;
    sum_f      = restart ? '0 : sum_q;
    discarding = (disc_f != '0);
    sum_n      = sum_f + SUM_W'(adc_i.adc_sample);
    taken_n    = taken_f + 1'b1;
    n_eff      = (samples_q == '0) ? TAKEN_W'(1) : samples_q;
    done       = !idle && !discarding && (taken_n >= n_eff);
    front_pot  = idle ? '0 : pot_f;
  end

  assign fold_busy         = (fold_cnt_q != '0);
  assign stat.reading_done = acc && done;
  assign stat.div_busy     = div_busy || fold_busy;

  // clamp the mean and scale it to the output range
  always_comb begin
    bits_eff = (out_bits_q > 5'd16) ? 5'd16 : out_bits_q;
    top      = VALUE_W'((17'd1 << bits_eff) - 17'd1);
    mean_c   = (div_quo > DIV_W'(ADC_FULL)) ? ADC_FULL : div_quo[SAMPLE_W-1:0];
    product  = PROD_W'(mean_c) * PROD_W'(top);
  end

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(sum_q);
    div_divisor  = DIVISOR_W'(n_eff);
    case (uw.op)
      OP_DIV_MEAN: begin
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // divide by 4095: fold the bits from bit 12 up back onto the low bits,
  // then one last step when the remainder lands on 4095 itself
  always_comb begin
    fold_hi    = fold_r_q[PROD_W-1:SAMPLE_W];
    fold_lo    = fold_r_q[SAMPLE_W-1:0];
    fold_cnt_d = fold_cnt_q;
    fold_r_d   = fold_r_q;
    fold_q_d   = fold_q_q;
    if (uw.op == OP_DIV_SCALE) begin
      fold_cnt_d = FOLD_CNT_W'(FOLD_STEPS);
      fold_r_d   = product;
      fold_q_d   = '0;
    end else if (fold_busy) begin
      fold_cnt_d = fold_cnt_q - 1'b1;
      if (fold_hi != '0) begin
        fold_q_d = fold_q_q + fold_hi;
        fold_r_d = PROD_W'(fold_lo) + PROD_W'(fold_hi);
      end else if (fold_lo == ADC_FULL) begin
        fold_q_d = fold_q_q + 1'b1;
        fold_r_d = '0;
      end
    end
  end

  // fold step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_cnt_q <= '0;
    end else begin
      fold_cnt_q <= fold_cnt_d;
    end
  end

  // fold working registers
  always_ff @(posedge clk_i) begin
    fold_r_q <= fold_r_d;
    fold_q_q <= fold_q_d;
  end

  // deadband compare and scan advance
  always_comb begin
    val      = fold_q_q;
    prev     = last_q[cur_pot_q];
    changed  = ({1'b0, val} > ({1'b0, prev} + {1'b0, margin_q}))
            || (({1'b0, val} + {1'b0, margin_q}) < {1'b0, prev});
    pot_inc  = {1'b0, cur_pot_q} + 1'b1;
    wrap     = (pot_inc >= count_eff);
    next_pot = wrap ? '0 : pot_inc[POT_W-1:0];
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pot_count_q <= 3'd4;
      samples_q   <= 8'd1;
      out_bits_q  <= 5'd12;
      margin_q    <= '0;
      chan_map_q  <= 8'd228;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_POT_COUNT:   pot_count_q <= cfg_wdata_i[CNT_POT_W-1:0];
        CFG_SAMPLES:     samples_q   <= cfg_wdata_i[TAKEN_W-1:0];
        CFG_OUT_BITS:    out_bits_q  <= cfg_wdata_i[4:0];
        CFG_MARGIN:      margin_q    <= cfg_wdata_i;
        CFG_CHANNEL_MAP: chan_map_q  <= cfg_wdata_i[2*POT_SLOTS-1:0];
        default:         pot_count_q <= pot_count_q;
      endcase
    end
  end

  // scan state and stored values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pot_q <= '0;
      disc_q    <= DISCARD_COUNT;
      taken_q   <= '0;
      sum_q     <= '0;
      for (int i = 0; i < POT_SLOTS; i++) begin
        last_q[i] <= '0;
      end
    end else if (acc && !idle) begin
      cur_pot_q <= pot_f;
      if (discarding) begin
        disc_q  <= disc_f - 1'b1;
        taken_q <= taken_f;
        sum_q   <= sum_f;
      end else begin
        disc_q  <= disc_f;
        taken_q <= taken_n;
        sum_q   <= sum_n;
      end
    end else if (uw.op == OP_UPDATE) begin
      if (changed) begin
        last_q[cur_pot_q] <= val;
      end
      cur_pot_q <= next_pot;
      disc_q    <= DISCARD_COUNT;
      taken_q   <= '0;
      sum_q     <= '0;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((acc && !done) || (uw.op == OP_UPDATE)) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (acc && !done) begin
      mux_q      <= chan_map_q[{front_pot, 1'b0} +: CHAN_W];
      ev_valid_q <= 1'b0;
      ev_pot_q   <= '0;
      ev_value_q <= '0;
      wrap_q     <= 1'b0;
    end else if (uw.op == OP_UPDATE) begin
      mux_q      <= chan_map_q[{next_pot, 1'b0} +: CHAN_W];
      ev_valid_q <= changed;
      ev_pot_q   <= changed ? cur_pot_q : '0;
      ev_value_q <= changed ? val : '0;
      wrap_q     <= wrap;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.mux_select  = mux_q;
  assign res_o.event_valid = ev_valid_q;
  assign res_o.event_pot   = ev_pot_q;
  assign res_o.event_value = ev_value_q;
  assign res_o.scan_wrap   = wrap_q;

  // the result slot is empty when a finished reading is written back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (uw.op == OP_UPDATE) |-> !out_valid_q)
    else $error("result overwritten at update");
  // the divider is idle whenever new items are taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (uw.op == OP_FRONT) |-> !div_busy)
    else $error("divider busy at front end");
  // during the discard phase nothing has been summed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (disc_q != '0) |-> (taken_q == '0) && (sum_q == '0))
    else $error("sum collected while discarding");
  // an event always carries a scaled value within range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (uw.op == OP_UPDATE) |-> (val <= top))
    else $error("scaled value above range");
  // the fold has settled to a remainder below 4095 by the write back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (uw.op == OP_UPDATE) |-> (fold_r_q < PROD_W'(ADC_FULL)))
    else $error("scale fold not settled");

endmodule
